[hdl/call_timing_profiler_top_assert.svh]
// Assertion macros for the call timing profiler.
`ifndef CALL_TIMING_PROFILER_TOP_ASSERT_SVH
`define CALL_TIMING_PROFILER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CTP_ASSERT_IMP(lbl, ante, cons, msg)
`define CTP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/ctp_pkg.sv]
package ctp_pkg;

  localparam int ENTRIES   = 64;
  localparam int PAIRS     = 256;
  localparam int STACK     = 64;
  localparam int TW        = 48;
  localparam int EW        = $clog2(ENTRIES);
  localparam int PW        = $clog2(PAIRS);
  localparam int SW        = $clog2(STACK);
  localparam logic [6:0] LEVEL_MAX = 7'd127;

  localparam logic [2:0] A_ENTER  = 3'd0;
  localparam logic [2:0] A_LEAVE  = 3'd1;
  localparam logic [2:0] A_RDENT  = 3'd2;
  localparam logic [2:0] A_RDPAIR = 3'd3;
  localparam logic [2:0] A_FLUSH  = 3'd4;
  localparam logic [2:0] A_CLEAR  = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_IGN   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_STK   = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  // configuration register indexes
  localparam logic [0:0] REG_SUBCALLS = 1'd0;
  localparam logic [0:0] REG_BUILTINS = 1'd1;

  typedef struct packed {
    logic [TW-1:0] total;
    logic [TW-1:0] inl;
    logic [31:0]   calls;
    logic [31:0]   rec;
    logic [6:0]    level;
  } stat_t;

  typedef struct packed {
    logic [31:0] key;
    stat_t       st;
  } entry_t;

  typedef struct packed {
    logic [EW-1:0] caller;
    logic [EW-1:0] callee;
    stat_t         st;
  } pair_t;

  typedef struct packed {
    logic [EW-1:0] ent;
    logic [TW-1:0] start;
    logic [TW-1:0] sub;
  } frame_t;

  typedef struct packed {
    logic [2:0]    status;
    logic          slot_valid;
    logic [31:0]   key;
    logic [5:0]    caller;
    logic [5:0]    callee;
    logic [31:0]   calls;
    logic [31:0]   rec;
    logic [TW-1:0] total;
    logic [TW-1:0] inl;
  } res_t;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic stat_t lvl_inc(stat_t s);
    stat_t r;
    r = s;
    if (s.level < LEVEL_MAX) r.level = s.level + 7'd1;
    return r;
  endfunction

  // charge one closed call
  function automatic stat_t acc(stat_t s, logic [TW-1:0] tt, logic [TW-1:0] it);
    stat_t r;
    r = s;
    if (s.level == 7'd1) begin
      r.level = '0;
      r.total = s.total + tt;
    end else begin
      if (s.level > 7'd1) r.level = s.level - 7'd1;
      r.rec = sat_inc(s.rec);
    end
    r.inl   = s.inl + it;
    r.calls = sat_inc(s.calls);
    return r;
  endfunction

endpackage

[hdl/call_timing_profiler_top.sv]
// Call timing profiler. Takes enter/leave events (function key + timestamp),
// keeps a 64-slot function table, a 256-slot caller/callee pair table and a
// 64-deep stack of open calls, all in single-write, registered-read memories
// driven by one small sequencer. One word is taken at a time; in_stall_o is
// high while a word is in work. Enter and leave search the tables slot by
// slot: enter scans the function table plus, with pair statistics on and a
// caller present, the pair table; leave makes the same table scan, closes the
// frame through S_CL_RD0, S_CL_RD1, S_CL_RD2 and S_CL_ACC, then does the pair
// scan; flush closes every open frame the same way, each with its pair scan. A
// finished result sits in the output register, so the next word is taken
// while it waits.
// Reset clears all valid bits at once; no clearing pass is needed.
`include "call_timing_profiler_top_assert.svh"
module call_timing_profiler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [0:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic        is_builtin_i,
  input  logic [31:0] func_key_i,
  input  logic [47:0] timestamp_i,
  input  logic [7:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        slot_valid_o,
  output logic [31:0] key_out_o,
  output logic [5:0]  caller_slot_o,
  output logic [5:0]  callee_slot_o,
  output logic [31:0] call_count_o,
  output logic [31:0] recursive_call_count_o,
  output logic [47:0] total_time_o,
  output logic [47:0] inline_time_o,
  output logic [6:0]  stack_depth_o,
  output logic        memory_exhausted_o
);

  localparam int EW = ctp_pkg::EW;
  localparam int PW = ctp_pkg::PW;
  localparam int SW = ctp_pkg::SW;
  localparam int TW = ctp_pkg::TW;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ESCAN_RD = 4'd1;
  localparam logic [3:0] S_ESCAN_CK = 4'd2;
  localparam logic [3:0] S_ENT_STK  = 4'd3;
  localparam logic [3:0] S_ENT_CALL = 4'd4;
  localparam logic [3:0] S_PSCAN_RD = 4'd5;
  localparam logic [3:0] S_PSCAN_CK = 4'd6;
  localparam logic [3:0] S_CL_RD0   = 4'd7;
  localparam logic [3:0] S_CL_RD1   = 4'd8;
  localparam logic [3:0] S_CL_RD2   = 4'd9;
  localparam logic [3:0] S_CL_ACC   = 4'd10;
  localparam logic [3:0] S_RDE_WAIT = 4'd11;
  localparam logic [3:0] S_RDP_WAIT = 4'd12;
  localparam logic [3:0] S_RDP_KEY  = 4'd13;
  localparam logic [3:0] S_DONE     = 4'd14;

  // control state
  logic [3:0]               state_q, state_d;
  logic                     ovalid_q, ovalid_d;
  logic [6:0]               fcnt_q, fcnt_d;
  logic                     nomem_q, nomem_d;
  logic [ctp_pkg::ENTRIES-1:0] eused_q, eused_d;
  logic [ctp_pkg::PAIRS-1:0]   pused_q, pused_d;
  logic                     sub_en_q, bi_en_q;

  // working payload
  logic [2:0]               op_q, op_d;
  logic [31:0]              key_q, key_d;
  logic [TW-1:0]            now_q, now_d;
  logic [PW-1:0]            cnt_q, cnt_d;
  logic                     free_q, free_d;
  logic [PW-1:0]            fidx_q, fidx_d;
  logic [EW-1:0]            e_q, e_d;
  logic [EW-1:0]            cal_q, cal_d;
  logic                     hp_q, hp_d;
  logic [TW-1:0]            tt_q, tt_d, sub_q, sub_d, it_q, it_d;
  ctp_pkg::entry_t          erec_q, erec_d;
  ctp_pkg::res_t            res_q, res_d, out_q, out_d;
  logic [6:0]               odepth_q, odepth_d;
  logic                     omex_q, omex_d;

  // memories
  ctp_pkg::entry_t emem_q [ctp_pkg::ENTRIES];
  ctp_pkg::pair_t  pmem_q [ctp_pkg::PAIRS];
  ctp_pkg::frame_t fmem_q [ctp_pkg::STACK];
  ctp_pkg::entry_t e_rd_q, e_wd;
  ctp_pkg::pair_t  p_rd_q, p_wd;
  ctp_pkg::frame_t f_rd_q, f_wd;
  logic            e_we, p_we, f_we;
  logic [EW-1:0]   e_wa, e_ra;
  logic [PW-1:0]   p_wa, p_ra;
  logic [SW-1:0]   f_wa, f_ra;

  logic            accept;
  logic [SW-1:0]   top, topm1;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign top        = fcnt_q[SW-1:0] - SW'(1);
  assign topm1      = fcnt_q[SW-1:0] - SW'(2);

  always_ff @(posedge clk_i) begin
    if (e_we) emem_q[e_wa] <= e_wd;
    e_rd_q <= emem_q[e_ra];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) pmem_q[p_wa] <= p_wd;
    p_rd_q <= pmem_q[p_ra];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) fmem_q[f_wa] <= f_wd;
    f_rd_q <= fmem_q[f_ra];
  end

  always_comb begin
    logic [EW-1:0]   ci;
    logic            ehit, elast, phit, plast;
    logic [EW-1:0]   esel;
    logic [PW-1:0]   psel;
    logic [3:0]      close_next;
    ctp_pkg::stat_t  fresh;

    state_d  = state_q;
    ovalid_d = ovalid_q;
    fcnt_d   = fcnt_q;
    nomem_d  = nomem_q;
    eused_d  = eused_q;
    pused_d  = pused_q;
    op_d     = op_q;
    key_d    = key_q;
    now_d    = now_q;
    cnt_d    = cnt_q;
    free_d   = free_q;
    fidx_d   = fidx_q;
    e_d      = e_q;
    cal_d    = cal_q;
    hp_d     = hp_q;
    tt_d     = tt_q;
    sub_d    = sub_q;
    it_d     = it_q;
    erec_d   = erec_q;
    res_d    = res_q;
    out_d    = out_q;
    odepth_d = odepth_q;
    omex_d   = omex_q;

    e_we = 1'b0;  e_wa = e_q;    e_ra = e_q;    e_wd = erec_q;
    p_we = 1'b0;  p_wa = cnt_q;  p_ra = cnt_q;  p_wd = p_rd_q;
    f_we = 1'b0;  f_wa = top;    f_ra = top;    f_wd = f_rd_q;

    ci    = cnt_q[EW-1:0];
    ehit  = eused_q[ci] && (e_rd_q.key == key_q);
    elast = (ci == EW'(ctp_pkg::ENTRIES - 1));
    esel  = free_q ? fidx_q[EW-1:0] : ci;
    phit  = pused_q[cnt_q] && (p_rd_q.caller == cal_q) && (p_rd_q.callee == e_q);
    plast = (cnt_q == PW'(ctp_pkg::PAIRS - 1));
    psel  = free_q ? fidx_q : cnt_q;
    fresh = '0;
    close_next = ((op_q == ctp_pkg::A_FLUSH) && (fcnt_d != 7'd0)) ? S_CL_RD0 : S_DONE;

    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = action_i;
          key_d  = func_key_i;
          now_d  = timestamp_i;
          res_d  = '0;
          cnt_d  = '0;
          free_d = 1'b0;
          e_ra   = read_index_i[EW-1:0];
          p_ra   = read_index_i[PW-1:0];
          if (((action_i == ctp_pkg::A_ENTER) || (action_i == ctp_pkg::A_LEAVE)) &&
              is_builtin_i && !bi_en_q) begin
            res_d.status = ctp_pkg::ST_IGN;
            state_d      = S_DONE;
          end else begin
            unique case (action_i)
              ctp_pkg::A_ENTER: state_d = S_ESCAN_RD;
              ctp_pkg::A_LEAVE: begin
                if (fcnt_q == 7'd0) begin
                  res_d.status = ctp_pkg::ST_IGN;
                  state_d      = S_DONE;
                end else begin
                  state_d = S_ESCAN_RD;
                end
              end
              ctp_pkg::A_RDENT: begin
                if ((read_index_i < 8'(ctp_pkg::ENTRIES)) &&
                    eused_q[read_index_i[EW-1:0]]) begin
                  state_d = S_RDE_WAIT;
                end else begin
                  res_d.status = ctp_pkg::ST_EMPTY;
                  state_d      = S_DONE;
                end
              end
              ctp_pkg::A_RDPAIR: begin
                if (pused_q[read_index_i[PW-1:0]]) begin
                  state_d = S_RDP_WAIT;
                end else begin
                  res_d.status = ctp_pkg::ST_EMPTY;
                  state_d      = S_DONE;
                end
              end
              ctp_pkg::A_FLUSH: state_d = (fcnt_q != 7'd0) ? S_CL_RD0 : S_DONE;
              ctp_pkg::A_CLEAR: begin
                eused_d = '0;
                pused_d = '0;
                fcnt_d  = '0;
                state_d = S_DONE;
              end
              default: begin
                res_d.status = ctp_pkg::ST_IGN;
                state_d      = S_DONE;
              end
            endcase
          end
        end
      end

      S_ESCAN_RD: begin
        e_ra    = ci;
        state_d = S_ESCAN_CK;
      end

      S_ESCAN_CK: begin
        if (ehit) begin
          e_d     = ci;
          erec_d  = e_rd_q;
          state_d = (op_q == ctp_pkg::A_ENTER) ? S_ENT_STK : S_CL_RD0;
        end else begin
          if (!eused_q[ci] && !free_q) begin
            free_d = 1'b1;
            fidx_d = cnt_q;
          end
          if (elast) begin
            if (op_q == ctp_pkg::A_ENTER) begin
              if (free_q || !eused_q[ci]) begin
                e_d         = esel;
                erec_d.key  = key_q;
                erec_d.st   = fresh;
                e_we        = 1'b1;
                e_wa        = esel;
                e_wd.key    = key_q;
                e_wd.st     = fresh;
                eused_d[esel] = 1'b1;
                state_d     = S_ENT_STK;
              end else begin
                nomem_d      = 1'b1;
                res_d.status = ctp_pkg::ST_FULL;
                state_d      = S_DONE;
              end
            end else begin
              // unknown key: drop the top call without statistics
              fcnt_d  = fcnt_q - 7'd1;
              state_d = S_DONE;
            end
          end else begin
            cnt_d   = cnt_q + PW'(1);
            state_d = S_ESCAN_RD;
          end
        end
      end

      S_ENT_STK: begin
        if (fcnt_q >= 7'(ctp_pkg::STACK)) begin
          nomem_d      = 1'b1;
          res_d.status = ctp_pkg::ST_STK;
          state_d      = S_DONE;
        end else begin
          e_we       = 1'b1;
          e_wa       = e_q;
          e_wd.key   = erec_q.key;
          e_wd.st    = ctp_pkg::lvl_inc(erec_q.st);
          f_we       = 1'b1;
          f_wa       = fcnt_q[SW-1:0];
          f_wd.ent   = e_q;
          f_wd.start = now_q;
          f_wd.sub   = '0;
          f_ra       = top;
          fcnt_d     = fcnt_q + 7'd1;
          if (sub_en_q && (fcnt_q != 7'd0)) begin
            state_d = S_ENT_CALL;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_ENT_CALL: begin
        cal_d   = f_rd_q.ent;
        cnt_d   = '0;
        free_d  = 1'b0;
        state_d = S_PSCAN_RD;
      end

      S_PSCAN_RD: begin
        p_ra    = cnt_q;
        state_d = S_PSCAN_CK;
      end

      S_PSCAN_CK: begin
        if (op_q == ctp_pkg::A_ENTER) begin
          if (phit) begin
            p_we    = 1'b1;
            p_wa    = cnt_q;
            p_wd.st = ctp_pkg::lvl_inc(p_rd_q.st);
            state_d = S_DONE;
          end else begin
            if (!pused_q[cnt_q] && !free_q) begin
              free_d = 1'b1;
              fidx_d = cnt_q;
            end
            if (plast) begin
              if (free_q || !pused_q[cnt_q]) begin
                p_we          = 1'b1;
                p_wa          = psel;
                p_wd.caller   = cal_q;
                p_wd.callee   = e_q;
                p_wd.st       = fresh;
                p_wd.st.level = 7'd1;
                pused_d[psel] = 1'b1;
              end else begin
                nomem_d      = 1'b1;
                res_d.status = ctp_pkg::ST_FULL;
              end
              state_d = S_DONE;
            end else begin
              cnt_d   = cnt_q + PW'(1);
              state_d = S_PSCAN_RD;
            end
          end
        end else begin
          if (phit) begin
            p_we    = 1'b1;
            p_wa    = cnt_q;
            p_wd.st = ctp_pkg::acc(p_rd_q.st, tt_q, it_q);
            state_d = close_next;
          end else if (plast) begin
            state_d = close_next;
          end else begin
            cnt_d   = cnt_q + PW'(1);
            state_d = S_PSCAN_RD;
          end
        end
      end

      S_CL_RD0: begin
        f_ra    = top;
        state_d = S_CL_RD1;
      end

      S_CL_RD1: begin
        tt_d  = now_q - f_rd_q.start;
        sub_d = f_rd_q.sub;
        if (op_q == ctp_pkg::A_FLUSH) e_d = f_rd_q.ent;
        f_ra    = topm1;
        state_d = S_CL_RD2;
      end

      S_CL_RD2: begin
        it_d  = tt_q - sub_q;
        cal_d = f_rd_q.ent;
        hp_d  = (fcnt_q > 7'd1);
        if (fcnt_q > 7'd1) begin
          // nested time goes to the caller frame
          f_we       = 1'b1;
          f_wa       = topm1;
          f_wd.ent   = f_rd_q.ent;
          f_wd.start = f_rd_q.start;
          f_wd.sub   = f_rd_q.sub + tt_q;
        end
        fcnt_d  = fcnt_q - 7'd1;
        e_ra    = e_q;
        state_d = S_CL_ACC;
      end

      S_CL_ACC: begin
        e_we     = 1'b1;
        e_wa     = e_q;
        e_wd.key = e_rd_q.key;
        e_wd.st  = ctp_pkg::acc(e_rd_q.st, tt_q, it_q);
        if (sub_en_q && hp_q) begin
          cnt_d   = '0;
          state_d = S_PSCAN_RD;
        end else begin
          state_d = close_next;
        end
      end

      S_RDE_WAIT: begin
        res_d.slot_valid = 1'b1;
        res_d.key        = e_rd_q.key;
        res_d.calls      = e_rd_q.st.calls;
        res_d.rec        = e_rd_q.st.rec;
        res_d.total      = e_rd_q.st.total;
        res_d.inl        = e_rd_q.st.inl;
        state_d          = S_DONE;
      end

      S_RDP_WAIT: begin
        res_d.slot_valid = 1'b1;
        res_d.caller     = p_rd_q.caller;
        res_d.callee     = p_rd_q.callee;
        res_d.calls      = p_rd_q.st.calls;
        res_d.rec        = p_rd_q.st.rec;
        res_d.total      = p_rd_q.st.total;
        res_d.inl        = p_rd_q.st.inl;
        e_ra             = p_rd_q.callee;
        state_d          = S_RDP_KEY;
      end

      S_RDP_KEY: begin
        res_d.key = e_rd_q.key;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!ovalid_q || !out_stall_i) begin
          out_d    = res_q;
          odepth_d = fcnt_q;
          omex_d   = nomem_q;
          if (op_q == ctp_pkg::A_FLUSH) nomem_d = 1'b0;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      fcnt_q   <= '0;
      nomem_q  <= 1'b0;
      eused_q  <= '0;
      pused_q  <= '0;
      sub_en_q <= 1'b1;
      bi_en_q  <= 1'b1;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      fcnt_q   <= fcnt_d;
      nomem_q  <= nomem_d;
      eused_q  <= eused_d;
      pused_q  <= pused_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == ctp_pkg::REG_SUBCALLS) sub_en_q <= cfg_data_i[0];
        else                                    bi_en_q  <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    now_q    <= now_d;
    cnt_q    <= cnt_d;
    free_q   <= free_d;
    fidx_q   <= fidx_d;
    e_q      <= e_d;
    cal_q    <= cal_d;
    hp_q     <= hp_d;
    tt_q     <= tt_d;
    sub_q    <= sub_d;
    it_q     <= it_d;
    erec_q   <= erec_d;
    res_q    <= res_d;
    out_q    <= out_d;
    odepth_q <= odepth_d;
    omex_q   <= omex_d;
  end

  assign out_valid_o            = ovalid_q;
  assign status_o               = out_q.status;
  assign slot_valid_o           = out_q.slot_valid;
  assign key_out_o              = out_q.key;
  assign caller_slot_o          = out_q.caller;
  assign callee_slot_o          = out_q.callee;
  assign call_count_o           = out_q.calls;
  assign recursive_call_count_o = out_q.rec;
  assign total_time_o           = out_q.total;
  assign inline_time_o          = out_q.inl;
  assign stack_depth_o          = odepth_q;
  assign memory_exhausted_o     = omex_q;

  `CTP_ASSERT_IMP(a_depth_bound, 1'b1, fcnt_q <= 7'(ctp_pkg::STACK), "stack count overflow")
  `CTP_ASSERT_NXT(a_accept_busy, accept, state_q != S_IDLE, "accepted word not in work")
  `CTP_ASSERT_NXT(a_done_loads, (state_q == S_DONE) && (!ovalid_q || !out_stall_i), ovalid_q && (state_q == S_IDLE), "result not loaded")
  `CTP_ASSERT_IMP(a_rise_from_done, $rose(ovalid_q), $past(state_q) == S_DONE, "result outside done")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  // reserved action codes, answered with "ignored"
  localparam logic [2:0] A_RSVD6 = 3'd6;
  localparam logic [2:0] A_RSVD7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 300000;

  // one result word as seen on the output ports
  typedef struct {
    bit [2:0]  status;
    bit        slot_valid;
    bit [31:0] key;
    bit [5:0]  caller;
    bit [5:0]  callee;
    bit [31:0] calls;
    bit [31:0] rec;
    bit [47:0] total;
    bit [47:0] inl;
    bit [6:0]  depth;
    bit        nomem;
  } word_t;

  // statistics of one function entry or caller/callee pair
  typedef struct {
    bit [47:0] tot;
    bit [47:0] inl;
    bit [31:0] calls;
    bit [31:0] rec;
    bit [6:0]  lvl;
  } tally_t;

  // Profiler model plus store of expected result words.
  class profile_board;
    bit        sub_en = 1'b1;
    bit        bi_en  = 1'b1;
    bit [31:0] ekey [ctp_pkg::ENTRIES];
    bit        eused[ctp_pkg::ENTRIES];
    tally_t    et   [ctp_pkg::ENTRIES];
    bit        pused[ctp_pkg::PAIRS];
    bit [5:0]  pcaller[ctp_pkg::PAIRS];
    bit [5:0]  pcallee[ctp_pkg::PAIRS];
    tally_t    pt   [ctp_pkg::PAIRS];
    bit [5:0]  fent  [ctp_pkg::STACK];
    bit [47:0] fstart[ctp_pkg::STACK];
    bit [47:0] fsub  [ctp_pkg::STACK];
    int        fcount = 0;
    bit        nomem  = 1'b0;
    word_t     expected_words[$];
    int        errors = 0;

    function bit [31:0] bump(bit [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function tally_t charge(tally_t s, bit [47:0] tt, bit [47:0] it);
      tally_t r;
      r = s;
      if (s.lvl == 7'd1) begin
        r.lvl = 7'd0;
        r.tot = s.tot + tt;
      end else begin
        if (s.lvl > 7'd1) r.lvl = s.lvl - 7'd1;
        r.rec = bump(s.rec);
      end
      r.inl   = s.inl + it;
      r.calls = bump(s.calls);
      return r;
    endfunction

    function int find_entry(bit [31:0] key);
      for (int i = 0; i < ctp_pkg::ENTRIES; i++)
        if (eused[i] && ekey[i] == key) return i;
      return -1;
    endfunction

    function int find_pair(bit [5:0] caller, bit [5:0] callee);
      for (int i = 0; i < ctp_pkg::PAIRS; i++)
        if (pused[i] && pcaller[i] == caller && pcallee[i] == callee) return i;
      return -1;
    endfunction

    function void close_top(int e, bit [47:0] now);
      int top;
      int p;
      bit [47:0] tt;
      bit [47:0] it;
      bit [5:0] caller;
      top = fcount - 1;
      tt = now - fstart[top];
      it = tt - fsub[top];
      caller = 6'd0;
      if (top > 0) begin
        caller = fent[top-1];
        fsub[top-1] = fsub[top-1] + tt;
      end
      fcount = top;
      et[e] = charge(et[e], tt, it);
      if (sub_en && top > 0) begin
        p = find_pair(caller, e[5:0]);
        if (p >= 0) pt[p] = charge(pt[p], tt, it);
      end
    endfunction

    function bit [2:0] enter(bit [31:0] key, bit [47:0] now);
      int e;
      int p;
      int top;
      e = find_entry(key);
      if (e < 0) begin
        for (int i = 0; i < ctp_pkg::ENTRIES && e < 0; i++)
          if (!eused[i]) e = i;
        if (e < 0) begin
          nomem = 1'b1;
          return ctp_pkg::ST_FULL;
        end
        eused[e] = 1'b1;
        ekey[e]  = key;
        et[e]    = '{default: 0};
      end
      if (fcount >= ctp_pkg::STACK) begin
        nomem = 1'b1;
        return ctp_pkg::ST_STK;
      end
      top = fcount;
      fent[top]   = e[5:0];
      fsub[top]   = '0;
      fstart[top] = now;
      fcount      = top + 1;
      if (et[e].lvl < ctp_pkg::LEVEL_MAX) et[e].lvl++;
      if (sub_en && top > 0) begin
        p = find_pair(fent[top-1], e[5:0]);
        if (p < 0) begin
          for (int i = 0; i < ctp_pkg::PAIRS && p < 0; i++)
            if (!pused[i]) p = i;
          if (p < 0) begin
            nomem = 1'b1;
            return ctp_pkg::ST_FULL;
          end
          pused[p]   = 1'b1;
          pcaller[p] = fent[top-1];
          pcallee[p] = e[5:0];
          pt[p]      = '{default: 0};
        end
        if (pt[p].lvl < ctp_pkg::LEVEL_MAX) pt[p].lvl++;
      end
      return ctp_pkg::ST_OK;
    endfunction

    // note one accepted input word and queue its expected result
    function void note_input(bit [2:0] action, bit builtin, bit [31:0] key,
                             bit [47:0] now, bit [7:0] idx);
      word_t w;
      int e;
      bit held;
      w = '{default: 0};
      if ((action == ctp_pkg::A_ENTER || action == ctp_pkg::A_LEAVE) &&
          builtin && !bi_en) begin
        w.status = ctp_pkg::ST_IGN;
      end else begin
        case (action)
          ctp_pkg::A_ENTER: w.status = enter(key, now);
          ctp_pkg::A_LEAVE: begin
            if (fcount == 0) begin
              w.status = ctp_pkg::ST_IGN;
            end else begin
              e = find_entry(key);
              if (e >= 0) close_top(e, now);
              else fcount--;
            end
          end
          ctp_pkg::A_RDENT: begin
            if (idx < ctp_pkg::ENTRIES && eused[idx]) begin
              w.slot_valid = 1'b1;
              w.key   = ekey[idx];
              w.calls = et[idx].calls;
              w.rec   = et[idx].rec;
              w.total = et[idx].tot;
              w.inl   = et[idx].inl;
            end else begin
              w.status = ctp_pkg::ST_EMPTY;
            end
          end
          ctp_pkg::A_RDPAIR: begin
            if (pused[idx]) begin
              w.slot_valid = 1'b1;
              w.key    = ekey[pcallee[idx]];
              w.caller = pcaller[idx];
              w.callee = pcallee[idx];
              w.calls  = pt[idx].calls;
              w.rec    = pt[idx].rec;
              w.total  = pt[idx].tot;
              w.inl    = pt[idx].inl;
            end else begin
              w.status = ctp_pkg::ST_EMPTY;
            end
          end
          ctp_pkg::A_FLUSH: while (fcount > 0) close_top(fent[fcount-1], now);
          ctp_pkg::A_CLEAR: begin
            for (int i = 0; i < ctp_pkg::ENTRIES; i++) eused[i] = 1'b0;
            for (int i = 0; i < ctp_pkg::PAIRS; i++) pused[i] = 1'b0;
            fcount = 0;
          end
          default: w.status = ctp_pkg::ST_IGN;
        endcase
      end
      held = nomem;
      if (action == ctp_pkg::A_FLUSH) nomem = 1'b0;
      w.depth = fcount[6:0];
      w.nomem = held;
      expected_words.push_back(w);
    endfunction

    function void cmp(string name, bit [63:0] want, bit [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(word_t got);
      word_t w;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      w = expected_words.pop_front();
      cmp("status", w.status, got.status);
      cmp("slot_valid", w.slot_valid, got.slot_valid);
      cmp("key_out", w.key, got.key);
      cmp("caller_slot", w.caller, got.caller);
      cmp("callee_slot", w.callee, got.callee);
      cmp("call_count", w.calls, got.calls);
      cmp("recursive_call_count", w.rec, got.rec);
      cmp("total_time", w.total, got.total);
      cmp("inline_time", w.inl, got.inl);
      cmp("stack_depth", w.depth, got.depth);
      cmp("memory_exhausted", w.nomem, got.nomem);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_idx = '0;
  logic [0:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  action = A_RSVD7;
  logic        is_builtin = 1'b0;
  logic [31:0] func_key = '0;
  logic [47:0] timestamp = '0;
  logic [7:0]  read_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic        slot_valid;
  logic [31:0] key_out;
  logic [5:0]  caller_slot;
  logic [5:0]  callee_slot;
  logic [31:0] call_count;
  logic [31:0] rec_count;
  logic [47:0] total_time;
  logic [47:0] inline_time;
  logic [6:0]  stack_depth;
  logic        mem_exhausted;

  profile_board board = new();
  bit        quiet = 1'b0;         // no idling on either side
  bit [47:0] ticks = 48'hFFFF_FFFF_F000;  // running timer, wraps early in the run
  bit [31:0] key_pool[12];
  int        stall_left = 0;
  int        idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  call_timing_profiler_top u_top (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we),
    .cfg_idx_i              (cfg_idx),
    .cfg_data_i             (cfg_data),
    .in_valid_i             (in_valid),
    .in_stall_o             (in_stall),
    .action_i               (action),
    .is_builtin_i           (is_builtin),
    .func_key_i             (func_key),
    .timestamp_i            (timestamp),
    .read_index_i           (read_index),
    .out_valid_o            (out_valid),
    .out_stall_i            (out_stall),
    .status_o               (status),
    .slot_valid_o           (slot_valid),
    .key_out_o              (key_out),
    .caller_slot_o          (caller_slot),
    .callee_slot_o          (callee_slot),
    .call_count_o           (call_count),
    .recursive_call_count_o (rec_count),
    .total_time_o           (total_time),
    .inline_time_o          (inline_time),
    .stack_depth_o          (stack_depth),
    .memory_exhausted_o     (mem_exhausted)
  );

  // Output side: check accepted words, generate stall bursts, run the watchdog.
  // Values are read before this edge's updates land, so sampling is race free.
  always @(posedge clk_i) begin
    word_t got;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        got.status     = status;
        got.slot_valid = slot_valid;
        got.key        = key_out;
        got.caller     = caller_slot;
        got.callee     = callee_slot;
        got.calls      = call_count;
        got.rec        = rec_count;
        got.total      = total_time;
        got.inl        = inline_time;
        got.depth      = stack_depth;
        got.nomem      = mem_exhausted;
        board.check_result(got);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
      // random stall bursts on the output side
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= !quiet;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Hand one word to the block; returns at the edge that accepts it.
  task automatic send_word(logic [2:0] act, logic bi, logic [31:0] key,
                           logic [47:0] ts, logic [7:0] idx);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    action     <= act;
    is_builtin <= bi;
    func_key   <= key;
    timestamp  <= ts;
    read_index <= idx;
    in_valid   <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    board.note_input(act, bi, key, ts, idx);
  endtask

  // event word with the running timer
  task automatic send_event(logic [2:0] act, logic [31:0] key);
    ticks = ticks + 48'($urandom_range(0, 400));
    send_word(act, 1'b0, key, ticks, 8'd0);
  endtask

  // Let every expected word drain, then a few spare cycles.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [0:0] val);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == ctp_pkg::REG_SUBCALLS) board.sub_en = val;
    else board.bi_en = val;
  endtask

  // Mostly well-formed call nesting, some noise.
  task automatic random_word();
    int r;
    logic [31:0] key;
    logic [2:0]  act;
    logic        bi;
    logic [47:0] ts;
    r   = $urandom_range(0, 99);
    key = key_pool[$urandom_range(0, 11)];
    if ($urandom_range(0, 19) == 0) key = $urandom;
    bi  = ($urandom_range(0, 9) == 0);
    act = ctp_pkg::A_ENTER;
    if (r < 42) act = ctp_pkg::A_ENTER;
    else if (r < 77) begin
      act = ctp_pkg::A_LEAVE;
      // usually leave the call on top of the stack
      if (board.fcount > 0 && $urandom_range(0, 9) < 8)
        key = board.ekey[board.fent[board.fcount-1]];
    end
    else if (r < 85) act = ctp_pkg::A_RDENT;
    else if (r < 93) act = ctp_pkg::A_RDPAIR;
    else if (r < 96) act = ctp_pkg::A_FLUSH;
    else if (r < 98) act = ctp_pkg::A_CLEAR;
    else act = r[0] ? A_RSVD6 : A_RSVD7;
    ticks = ticks + 48'($urandom_range(0, 600));
    ts = ticks;
    if ($urandom_range(0, 29) == 0) begin
      ts = 48'({$urandom, $urandom});
      ticks = ts;
    end
    send_word(act, bi, key, ts, 8'($urandom));
  endtask

  initial begin
    key_pool = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h10, 32'h11, 32'h12, 32'h13, 32'hDEAD_0001,
                 32'h7FFF_FFFF};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: timer extremes, mismatched and unknown leaves, reads, codes
    send_word(ctp_pkg::A_LEAVE, 1'b0, 32'h0, 48'h0, 8'd0);             // nothing open
    send_word(ctp_pkg::A_ENTER, 1'b0, 32'h0, 48'h0, 8'd0);
    send_word(ctp_pkg::A_ENTER, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'd0);
    send_word(ctp_pkg::A_LEAVE, 1'b0, 32'h0, 48'h10, 8'd0);            // not the top call
    send_word(ctp_pkg::A_LEAVE, 1'b0, 32'h1234_5678, 48'h20, 8'd0);    // unknown key
    send_word(ctp_pkg::A_ENTER, 1'b0, 32'h1, 48'h30, 8'd0);
    send_word(ctp_pkg::A_LEAVE, 1'b0, 32'h1, 48'h40, 8'd0);
    send_word(ctp_pkg::A_ENTER, 1'b0, 32'h5555_5555, 48'h50, 8'd0);
    send_word(ctp_pkg::A_LEAVE, 1'b0, 32'h1, 48'h60, 8'd0);            // level already zero
    send_word(ctp_pkg::A_ENTER, 1'b0, 32'h1, 48'h70, 8'd0);
    send_word(ctp_pkg::A_ENTER, 1'b0, 32'h1, 48'h80, 8'd0);            // recursion
    send_word(ctp_pkg::A_LEAVE, 1'b0, 32'h1, 48'h90, 8'd0);
    send_word(ctp_pkg::A_RDENT, 1'b0, 32'h0, 48'h0, 8'd0);
    send_word(ctp_pkg::A_RDENT, 1'b0, 32'h0, 48'h0, 8'd1);
    send_word(ctp_pkg::A_RDENT, 1'b0, 32'h0, 48'h0, 8'd63);
    send_word(ctp_pkg::A_RDENT, 1'b0, 32'h0, 48'h0, 8'd64);            // out of range
    send_word(ctp_pkg::A_RDPAIR, 1'b0, 32'h0, 48'h0, 8'd0);
    send_word(ctp_pkg::A_RDPAIR, 1'b0, 32'h0, 48'h0, 8'd255);
    send_word(A_RSVD6, 1'b1, 32'h0, 48'h0, 8'hFF);
    send_word(A_RSVD7, 1'b0, 32'h0, 48'h0, 8'd0);
    send_word(ctp_pkg::A_FLUSH, 1'b0, 32'h0, 48'hA0, 8'd0);
    send_word(ctp_pkg::A_CLEAR, 1'b0, 32'h0, 48'h0, 8'd0);

    // built-in events refused
    write_reg(ctp_pkg::REG_BUILTINS, 1'b0);
    send_word(ctp_pkg::A_ENTER, 1'b1, 32'h2, 48'h100, 8'd0);
    send_word(ctp_pkg::A_ENTER, 1'b0, 32'h2, 48'h110, 8'd0);
    send_word(ctp_pkg::A_LEAVE, 1'b1, 32'h2, 48'h120, 8'd0);
    send_word(ctp_pkg::A_LEAVE, 1'b0, 32'h2, 48'h130, 8'd0);
    write_reg(ctp_pkg::REG_BUILTINS, 1'b1);

    // nested enters fill table and stack, then one new key, then one more call
    send_word(ctp_pkg::A_CLEAR, 1'b0, 32'h0, 48'h0, 8'd0);
    for (int i = 0; i < ctp_pkg::ENTRIES; i++) send_event(ctp_pkg::A_ENTER, 32'h100 + i);
    send_event(ctp_pkg::A_ENTER, 32'h9999);
    send_event(ctp_pkg::A_ENTER, 32'h100);
    send_event(ctp_pkg::A_FLUSH, 32'h0);
    send_event(ctp_pkg::A_FLUSH, 32'h0);

    // pair table full: call chains over 17 functions, one key stride per chain
    send_word(ctp_pkg::A_CLEAR, 1'b0, 32'h0, 48'h0, 8'd0);
    for (int s = 1; s <= 16; s++) begin
      for (int k = 0; k <= 17; k++)
        send_event(ctp_pkg::A_ENTER, 32'h2000 + 32'((k * s) % 17));
      send_event(ctp_pkg::A_FLUSH, 32'h0);
    end
    send_word(ctp_pkg::A_RDPAIR, 1'b0, 32'h0, 48'h0, 8'd255);
    send_event(ctp_pkg::A_FLUSH, 32'h0);
    send_word(ctp_pkg::A_CLEAR, 1'b0, 32'h0, 48'h0, 8'd0);

    // random phases across register settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(ctp_pkg::REG_SUBCALLS, 1'(ph % 2 == 0));
      write_reg(ctp_pkg::REG_BUILTINS, 1'(ph < 2 || ph == 4));
      if (ph == 4) quiet = 1'b1;
      repeat (70) random_word();
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (board.errors == 0 && board.expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
